@@ rtl/sprite_animation_slot_table_assert.svh @@
// ----------------------------------------------------------------------------
// sprite animation slot table assertion macros
// shorthand for clocked assertions with synchronous reset disable
// ----------------------------------------------------------------------------
`ifndef SPRITE_ANIMATION_SLOT_TABLE_ASSERT_SVH
`define SPRITE_ANIMATION_SLOT_TABLE_ASSERT_SVH

// condition implies consequence in the same cycle
`define SPR_ASSERT_NOW(name, clk, rst, cond, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
    else $error("assertion failed");

// condition implies consequence in the next cycle
`define SPR_ASSERT_NEXT(name, clk, rst, cond, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ rtl/spr_anim_pkg.sv @@
// ----------------------------------------------------------------------------
// sprite animation slot table package
// beat types, operation and result codes, state ram entry, fsm states
// ----------------------------------------------------------------------------
package spr_anim_pkg;

  localparam int SLOTS_DEFAULT = 16;

  typedef enum logic [2:0] {
    OP_TICK      = 3'd0,
    OP_ALLOC     = 3'd1,
    OP_FREE      = 3'd2,
    OP_PLACE     = 3'd3,
    OP_SET_ANIM  = 3'd4,
    OP_SET_FRAME = 3'd5,
    OP_QUERY     = 3'd6
  } op_t;

  typedef enum logic [1:0] {
    KIND_ACK       = 2'd0,
    KIND_FRAME     = 2'd1,
    KIND_TICK_DONE = 2'd2,
    KIND_QUERY     = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    STATUS_OK      = 2'd0,
    STATUS_INVALID = 2'd1,
    STATUS_FULL    = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_TICK,
    ST_TICK_END,
    ST_ALLOC
  } state_t;

  typedef struct packed {
    logic [2:0]  op;
    logic [3:0]  slot;
    logic        paused;
    logic        placed;
    logic        ui_layer;
    logic [7:0]  anim_id;
    logic [7:0]  speed;
    logic [15:0] frame_total;
    logic        loop_mode;
    logic [15:0] base_frame;
    logic [15:0] frame;
    logic [15:0] frame_limit;
  } in_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [1:0]  status;
    logic [3:0]  slot_out;
    logic [15:0] shown_frame;
    logic [15:0] rel_frame;
    logic        anim_done;
    logic        last;
  } out_t;

  typedef struct packed {
    logic [7:0]  anim_id;
    logic [7:0]  speed;
    logic [15:0] frame_total;
    logic        loop_mode;
    logic [15:0] base_frame;
    logic [15:0] frame;
    logic [7:0]  counter;
  } entry_t;

endpackage

@@ rtl/sprite_animation_slot_table.sv @@
// ----------------------------------------------------------------------------
// sprite animation slot table
// tick: walks every slot in ST_TICK, then ST_TICK_END emits the done beat; rsp_ready stalls hold either
// alloc scans for the lowest free slot, other ops emit their result from ST_EXEC, then back to idle
// reset clears slot flags and control, ram content unused until alloc
// ----------------------------------------------------------------------------
module sprite_animation_slot_table #(
  parameter int SLOTS = spr_anim_pkg::SLOTS_DEFAULT,
  localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_ready,
  input  spr_anim_pkg::in_t  req,
  output logic               rsp_valid,
  input  logic               rsp_ready,
  output spr_anim_pkg::out_t rsp
);

  import spr_anim_pkg::*;

  localparam int EW = $bits(entry_t);
  localparam logic [AW-1:0] LAST_IDX = AW'(SLOTS - 1);
  localparam logic [6:0] SLOTS_W = 7'(SLOTS);

  state_t state, state_next;
  in_t    req_q;
  logic [AW-1:0] idx, idx_next;
  logic [SLOTS-1:0] active, active_next;
  logic [SLOTS-1:0] placed, placed_next;
  logic [SLOTS-1:0] screen, screen_next;
  logic [SLOTS-1:0] anim_valid, anim_valid_next;

  logic          accept;
  logic          out_free;
  logic          rd_en, wr_en;
  logic [AW-1:0] rd_addr, wr_addr;
  entry_t        rd_data, wr_data;
  logic          emit, finish;
  out_t          emit_data;

  logic [AW-1:0] slot_addr;
  logic          slot_ok;

  logic        elig, step, frame_end, tick_emit, tick_go;
  logic [7:0]  cnt_inc;
  logic [15:0] frame_inc, frame_new, tick_shown, query_shown;
  entry_t      tick_entry;

  spr_anim_ram #(
    .WIDTH(EW),
    .DEPTH(SLOTS)
  ) u_ram (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  assign req_ready = (state == ST_IDLE);
  assign accept    = req_valid && req_ready;
  assign out_free  = !rsp_valid || rsp_ready;

  assign slot_addr = AW'(req_q.slot);
  assign slot_ok   = ({3'b000, req_q.slot} < SLOTS_W) && active[slot_addr];

  // per-slot tick step on the entry read for idx
  always_comb begin
    elig = active[idx] && placed[idx] && anim_valid[idx] &&
           (!req_q.paused || screen[idx]);
    cnt_inc   = rd_data.counter + 8'd1;
    step      = (cnt_inc >= rd_data.speed);
    frame_inc = rd_data.frame + 16'd1;
    frame_end = (frame_inc >= rd_data.frame_total);
    if (!step) begin
      frame_new = rd_data.frame;
    end else if (frame_end) begin
      frame_new = rd_data.loop_mode ? 16'd0 : rd_data.frame_total - 16'd1;
    end else begin
      frame_new = frame_inc;
    end
    tick_emit  = elig && step && (frame_new != rd_data.frame);
    tick_go    = !(tick_emit && !out_free);
    tick_shown = rd_data.base_frame + frame_new;
    tick_entry = rd_data;
    tick_entry.frame   = frame_new;
    tick_entry.counter = step ? 8'd0 : cnt_inc;
    query_shown = rd_data.base_frame + rd_data.frame;
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          if (req.op == OP_TICK) begin
            state_next = ST_TICK;
          end else if (req.op == OP_ALLOC) begin
            state_next = ST_ALLOC;
          end else begin
            state_next = ST_EXEC;
          end
        end
      end
      ST_TICK: begin
        if (tick_go && (idx == LAST_IDX)) begin
          state_next = ST_TICK_END;
        end
      end
      ST_EXEC, ST_TICK_END, ST_ALLOC: begin
        if (finish) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // outputs, ram access, flag updates
  always_comb begin
    rd_en     = 1'b0;
    rd_addr   = '0;
    wr_en     = 1'b0;
    wr_addr   = idx;
    wr_data   = rd_data;
    emit      = 1'b0;
    finish    = 1'b0;
    emit_data = '0;
    idx_next  = idx;
    active_next     = active;
    placed_next     = placed;
    screen_next     = screen;
    anim_valid_next = anim_valid;
    case (state)
      ST_IDLE: begin
        idx_next = '0;
        if (accept) begin
          rd_en   = 1'b1;
          rd_addr = (req.op == OP_TICK) ? '0 : AW'(req.slot);
        end
      end
      ST_EXEC: begin
        if (out_free) begin
          emit   = 1'b1;
          finish = 1'b1;
          emit_data.last     = 1'b1;
          emit_data.slot_out = req_q.slot;
          wr_addr            = slot_addr;
          case (req_q.op)
            OP_FREE, OP_PLACE, OP_SET_ANIM, OP_SET_FRAME, OP_QUERY: begin
              if (!slot_ok) begin
                emit_data.status = STATUS_INVALID;
                if (req_q.op == OP_QUERY) begin
                  emit_data.kind      = KIND_QUERY;
                  emit_data.anim_done = 1'b1;
                end
              end else begin
                case (req_q.op)
                  OP_FREE: begin
                    active_next[slot_addr] = 1'b0;
                    placed_next[slot_addr] = 1'b0;
                  end
                  OP_PLACE: begin
                    placed_next[slot_addr] = req_q.placed;
                    screen_next[slot_addr] = req_q.ui_layer;
                  end
                  OP_SET_ANIM: begin
                    if (!(anim_valid[slot_addr] && (rd_data.anim_id == req_q.anim_id))) begin
                      wr_en = 1'b1;
                      wr_data.anim_id     = req_q.anim_id;
                      wr_data.speed       = req_q.speed;
                      wr_data.frame_total = req_q.frame_total;
                      wr_data.loop_mode   = req_q.loop_mode;
                      wr_data.base_frame  = req_q.base_frame;
                      wr_data.frame       = 16'd0;
                      wr_data.counter     = 8'd0;
                      anim_valid_next[slot_addr] = 1'b1;
                      emit_data.kind        = KIND_FRAME;
                      emit_data.shown_frame = req_q.base_frame;
                    end
                  end
                  OP_SET_FRAME: begin
                    if (req_q.frame >= req_q.frame_limit) begin
                      emit_data.status = STATUS_INVALID;
                    end else if (rd_data.frame == req_q.frame) begin
                      emit_data.rel_frame = req_q.frame;
                    end else begin
                      wr_en = 1'b1;
                      wr_data.frame   = req_q.frame;
                      wr_data.counter = 8'd0;
                      emit_data.kind        = KIND_FRAME;
                      emit_data.shown_frame = req_q.frame;
                      emit_data.rel_frame   = req_q.frame;
                    end
                  end
                  default: begin
                    emit_data.kind      = KIND_QUERY;
                    emit_data.rel_frame = rd_data.frame;
                    if (anim_valid[slot_addr]) begin
                      emit_data.shown_frame = query_shown;
                      emit_data.anim_done   = !rd_data.loop_mode &&
                        ((rd_data.frame_total == 16'd0) ||
                         (rd_data.frame >= rd_data.frame_total - 16'd1));
                    end else begin
                      emit_data.shown_frame = rd_data.frame;
                      emit_data.anim_done   = 1'b1;
                    end
                  end
                endcase
              end
            end
            default: begin
              emit_data.status   = STATUS_INVALID;
              emit_data.slot_out = 4'd0;
            end
          endcase
        end
      end
      ST_TICK: begin
        wr_data = tick_entry;
        if (tick_go) begin
          wr_en = elig;
          emit  = tick_emit;
          emit_data.kind        = KIND_FRAME;
          emit_data.slot_out    = 4'(idx);
          emit_data.shown_frame = tick_shown;
          emit_data.rel_frame   = frame_new;
          if (idx != LAST_IDX) begin
            idx_next = idx + AW'(1);
            rd_en    = 1'b1;
            rd_addr  = idx + AW'(1);
          end
        end
      end
      ST_TICK_END: begin
        if (out_free) begin
          emit   = 1'b1;
          finish = 1'b1;
          emit_data.kind = KIND_TICK_DONE;
          emit_data.last = 1'b1;
        end
      end
      ST_ALLOC: begin
        wr_data = '0;
        if (!active[idx]) begin
          if (out_free) begin
            emit   = 1'b1;
            finish = 1'b1;
            wr_en  = 1'b1;
            emit_data.slot_out = 4'(idx);
            emit_data.last     = 1'b1;
            active_next[idx]     = 1'b1;
            placed_next[idx]     = 1'b0;
            screen_next[idx]     = 1'b0;
            anim_valid_next[idx] = 1'b0;
          end
        end else if (idx == LAST_IDX) begin
          if (out_free) begin
            emit   = 1'b1;
            finish = 1'b1;
            emit_data.status = STATUS_FULL;
            emit_data.last   = 1'b1;
          end
        end else begin
          idx_next = idx + AW'(1);
        end
      end
      default: begin
        finish = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      idx        <= '0;
      rsp_valid  <= 1'b0;
      active     <= '0;
      placed     <= '0;
      screen     <= '0;
      anim_valid <= '0;
    end else begin
      state      <= state_next;
      idx        <= idx_next;
      active     <= active_next;
      placed     <= placed_next;
      screen     <= screen_next;
      anim_valid <= anim_valid_next;
      if (emit) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_q <= req;
    end
    if (emit) begin
      rsp <= emit_data;
    end
  end

endmodule

@@ rtl/spr_anim_ram.sv @@
// ----------------------------------------------------------------------------
// generic single write, single read ram
// one write port, one read port with registered read data
// ----------------------------------------------------------------------------
module spr_anim_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ rtl/spr_anim_checker.sv @@
// ----------------------------------------------------------------------------
// sprite animation slot table checker
// port-level assertions on beat ordering, bound to the top level
// ----------------------------------------------------------------------------
`include "sprite_animation_slot_table_assert.svh"

module spr_anim_checker (
  input logic               clk,
  input logic               rst,
  input logic               req_valid,
  input logic               req_ready,
  input spr_anim_pkg::in_t  req,
  input logic               rsp_valid,
  input logic               rsp_ready,
  input spr_anim_pkg::out_t rsp
);

  import spr_anim_pkg::*;

  // stalled result beat holds
  `SPR_ASSERT_NEXT(a_rsp_hold, clk, rst, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp))

  // one request in flight at a time
  `SPR_ASSERT_NEXT(a_one_in_flight, clk, rst, req_valid && req_ready, !req_ready)

  // tick done always closes its request
  `SPR_ASSERT_NOW(a_tick_done_last, clk, rst, rsp_valid && rsp.kind == KIND_TICK_DONE, rsp.last && rsp.status == STATUS_OK)

  // only tick frame changes leave a request open
  `SPR_ASSERT_NOW(a_open_is_frame, clk, rst, rsp_valid && !rsp.last, rsp.kind == KIND_FRAME && rsp.status == STATUS_OK)

endmodule

bind sprite_animation_slot_table spr_anim_checker u_checker (.*);

@@ sim/sprite_animation_slot_table_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sprite animation slot table testbench
// drives alloc, free, placement, animation, frame, query and tick commands
// through the request channel and checks every response beat, in order, field
// by field against the directed table's expected beat or a behavioral model kept in this bench;
// a directed table goes first, then random command sequences with random
// idling on both channels, a long response hold-off and a full drain pause
// ----------------------------------------------------------------------------
module sprite_animation_slot_table_tb;
  import spr_anim_pkg::*;

  localparam int NSLOT = SLOTS_DEFAULT;
  localparam logic [2:0] OP_UNKNOWN = 3'd7;
  localparam int RAND_ITEMS = 100;
  localparam int MAX_IDLE = 14;
  localparam int HOLD_CYCLES = 400;
  localparam int STALL_LIMIT = 3000;
  localparam int DRAIN_CYCLES = 2 * NSLOT + 8;
  localparam int REPORT_MAX = 10;
  localparam out_t NO_BEAT = '0;

  typedef struct {
    logic [2:0]  op;
    logic [3:0]  slot;
    bit          f1;
    bit          f2;
    logic [7:0]  id;
    logic [7:0]  spd;
    logic [15:0] a;
    logic [15:0] b;
    bit          typed;
    out_t        want;
  } plan_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic rsp_ready = 1'b0;
  logic req_ready;
  logic rsp_valid;
  in_t  req = '0;
  out_t rsp;

  // model of the slot table
  bit        s_active   [NSLOT];
  bit        s_scene    [NSLOT];
  bit        s_screen   [NSLOT];
  bit        s_animated [NSLOT];
  bit        s_loop     [NSLOT];
  bit [7:0]  s_id       [NSLOT];
  bit [7:0]  s_speed    [NSLOT];
  bit [7:0]  s_count    [NSLOT];
  bit [15:0] s_nframes  [NSLOT];
  bit [15:0] s_base     [NSLOT];
  bit [15:0] s_frame    [NSLOT];

  out_t step_beats[$];
  out_t answers_due[$];
  int   errors = 0;
  int   beats_sent = 0;
  int   stall_cycles = 0;
  bit   hold_rsp = 1'b0;
  bit   req_idle = 1'b1;
  bit   rsp_idle = 1'b1;

  sprite_animation_slot_table #(
    .SLOTS(NSLOT)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req      (req),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp      (rsp)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic out_t beat_of(kind_t k, status_t st, int sl, logic [15:0] shown,
                                   logic [15:0] rel, bit done, bit fin);
    out_t b;
    b.kind        = k;
    b.status      = st;
    b.slot_out    = sl[3:0];
    b.shown_frame = shown;
    b.rel_frame   = rel;
    b.anim_done   = done;
    b.last        = fin;
    return b;
  endfunction

  function automatic string beat_text(out_t b);
    return $sformatf("kind %0d status %0d slot %0d shown %h rel %h done %0b last %0b",
                     b.kind, b.status, b.slot_out, b.shown_frame, b.rel_frame,
                     b.anim_done, b.last);
  endfunction

  // updates the model for one command and leaves its beats in step_beats
  function automatic void animate_slots(in_t c);
    int          i;
    int unsigned s;
    bit          hit;
    bit          done;
    bit [15:0]   f;
    bit [15:0]   old;
    bit [15:0]   lastf;
    step_beats.delete();
    s = c.slot;
    case (c.op)
      OP_TICK: begin
        for (i = 0; i < NSLOT; i++) begin
          if (s_active[i] && s_scene[i] && s_animated[i] && !(c.paused && !s_screen[i])) begin
            s_count[i] = s_count[i] + 8'd1;
            if (s_count[i] >= s_speed[i]) begin
              old = s_frame[i];
              f = old + 16'd1;
              s_count[i] = '0;
              if (f >= s_nframes[i]) f = s_loop[i] ? 16'd0 : s_nframes[i] - 16'd1;
              s_frame[i] = f;
              if (f != old) begin
                step_beats.push_back(beat_of(KIND_FRAME, STATUS_OK, i, s_base[i] + f, f,
                                             1'b0, 1'b0));
              end
            end
          end
        end
        step_beats.push_back(beat_of(KIND_TICK_DONE, STATUS_OK, 0, 16'd0, 16'd0, 1'b0, 1'b1));
      end
      OP_ALLOC: begin
        hit = 1'b0;
        for (i = 0; i < NSLOT; i++) begin
          if (!hit && !s_active[i]) begin
            hit = 1'b1;
            s_active[i]   = 1'b1;
            s_scene[i]    = 1'b0;
            s_screen[i]   = 1'b0;
            s_animated[i] = 1'b0;
            s_id[i]       = '0;
            s_frame[i]    = '0;
            s_count[i]    = '0;
            step_beats.push_back(beat_of(KIND_ACK, STATUS_OK, i, 16'd0, 16'd0, 1'b0, 1'b1));
          end
        end
        if (!hit) begin
          step_beats.push_back(beat_of(KIND_ACK, STATUS_FULL, 0, 16'd0, 16'd0, 1'b0, 1'b1));
        end
      end
      OP_UNKNOWN: begin
        step_beats.push_back(beat_of(KIND_ACK, STATUS_INVALID, 0, 16'd0, 16'd0, 1'b0, 1'b1));
      end
      default: begin
        if (s >= NSLOT || !s_active[s]) begin
          if (c.op == OP_QUERY) begin
            step_beats.push_back(beat_of(KIND_QUERY, STATUS_INVALID, s, 16'd0, 16'd0,
                                         1'b1, 1'b1));
          end else begin
            step_beats.push_back(beat_of(KIND_ACK, STATUS_INVALID, s, 16'd0, 16'd0,
                                         1'b0, 1'b1));
          end
        end else begin
          case (c.op)
            OP_FREE: begin
              s_scene[s]  = 1'b0;
              s_active[s] = 1'b0;
              step_beats.push_back(beat_of(KIND_ACK, STATUS_OK, s, 16'd0, 16'd0, 1'b0, 1'b1));
            end
            OP_PLACE: begin
              s_scene[s]  = c.placed;
              s_screen[s] = c.ui_layer;
              step_beats.push_back(beat_of(KIND_ACK, STATUS_OK, s, 16'd0, 16'd0, 1'b0, 1'b1));
            end
            OP_SET_ANIM: begin
              if (s_animated[s] && s_id[s] == c.anim_id) begin
                step_beats.push_back(beat_of(KIND_ACK, STATUS_OK, s, 16'd0, 16'd0,
                                             1'b0, 1'b1));
              end else begin
                s_animated[s] = 1'b1;
                s_id[s]       = c.anim_id;
                s_speed[s]    = c.speed;
                s_nframes[s]  = c.frame_total;
                s_loop[s]     = c.loop_mode;
                s_base[s]     = c.base_frame;
                s_frame[s]    = '0;
                s_count[s]    = '0;
                step_beats.push_back(beat_of(KIND_FRAME, STATUS_OK, s, s_base[s], 16'd0,
                                             1'b0, 1'b1));
              end
            end
            OP_SET_FRAME: begin
              if (c.frame >= c.frame_limit) begin
                step_beats.push_back(beat_of(KIND_ACK, STATUS_INVALID, s, 16'd0, 16'd0,
                                             1'b0, 1'b1));
              end else if (s_frame[s] == c.frame) begin
                step_beats.push_back(beat_of(KIND_ACK, STATUS_OK, s, 16'd0, c.frame,
                                             1'b0, 1'b1));
              end else begin
                s_frame[s] = c.frame;
                s_count[s] = '0;
                step_beats.push_back(beat_of(KIND_FRAME, STATUS_OK, s, c.frame, c.frame,
                                             1'b0, 1'b1));
              end
            end
            default: begin
              f = s_frame[s];
              if (s_animated[s]) begin
                lastf = s_nframes[s] - 16'd1;
                done = s_loop[s] ? 1'b0 : (s_nframes[s] == 16'd0 || f >= lastf);
                step_beats.push_back(beat_of(KIND_QUERY, STATUS_OK, s, s_base[s] + f, f,
                                             done, 1'b1));
              end else begin
                step_beats.push_back(beat_of(KIND_QUERY, STATUS_OK, s, f, f, 1'b1, 1'b1));
              end
            end
          endcase
        end
      end
    endcase
  endfunction

  function automatic int lowest_free();
    foreach (s_active[i]) if (!s_active[i]) return i;
    return -1;
  endfunction

  function automatic int pick_active();
    int cand[$];
    foreach (s_active[i]) if (s_active[i]) cand.push_back(i);
    if (cand.size() == 0) return $urandom_range(0, NSLOT - 1);
    return cand[$urandom_range(0, cand.size() - 1)];
  endfunction

  function automatic plan_row_t cmd_row(logic [2:0] op, int sl, bit f1, bit f2, int id,
                                        int spd, int a, int b);
    plan_row_t r;
    r.op    = op;
    r.slot  = sl[3:0];
    r.f1    = f1;
    r.f2    = f2;
    r.id    = id[7:0];
    r.spd   = spd[7:0];
    r.a     = a[15:0];
    r.b     = b[15:0];
    r.typed = 1'b0;
    r.want  = NO_BEAT;
    return r;
  endfunction

  // fields the command does not use carry random bits
  function automatic in_t build_cmd(plan_row_t r);
    bit [95:0] raw;
    in_t       c;
    raw = {$urandom, $urandom, $urandom};
    c = raw[$bits(in_t)-1:0];
    c.op   = r.op;
    c.slot = r.slot;
    case (r.op)
      OP_TICK: c.paused = r.f1;
      OP_PLACE: begin
        c.placed   = r.f1;
        c.ui_layer = r.f2;
      end
      OP_SET_ANIM: begin
        c.loop_mode   = r.f1;
        c.anim_id     = r.id;
        c.speed       = r.spd;
        c.frame_total = r.a;
        c.base_frame  = r.b;
      end
      OP_SET_FRAME: begin
        c.frame       = r.a;
        c.frame_limit = r.b;
      end
      default: ;
    endcase
    return c;
  endfunction

  // called at a falling edge, returns at the falling edge after the beat
  task automatic send_row(plan_row_t r);
    in_t c;
    int  gap;
    c = build_cmd(r);
    gap = req_idle ? $urandom_range(0, MAX_IDLE) : 0;
    if (gap > 0) begin
      req_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    req = c;
    req_valid = 1'b1;
    do @(posedge clk); while (!req_ready);
    animate_slots(c);
    if (r.typed) answers_due.push_back(r.want);
    else foreach (step_beats[k]) answers_due.push_back(step_beats[k]);
    beats_sent++;
    @(negedge clk);
  endtask

  task automatic send_anim(int sl);
    int id;
    int spd;
    int fc;
    int pick;
    id = ($urandom_range(0, 4) == 0) ? s_id[sl] : $urandom_range(0, 255);
    spd = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 2);
    pick = $urandom_range(0, 7);
    fc = (pick == 0) ? 0 : (pick == 1) ? $urandom_range(0, 65535) : $urandom_range(1, 6);
    send_row(cmd_row(OP_SET_ANIM, sl, 1'($urandom_range(0, 1)), 1'b0, id, spd, fc,
                     $urandom_range(0, 65535)));
  endtask

  always @(posedge clk) begin
    if (rst || (req_valid && req_ready) || (rsp_valid && rsp_ready)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("sprite_animation_slot_table_tb: errors");
      $finish;
    end
  end

  initial begin : rsp_side
    int   gap;
    out_t want;
    wait (rst == 1'b0);
    forever begin
      @(negedge clk);
      if (hold_rsp) begin
        rsp_ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_rsp = 1'b0;
      end
      gap = rsp_idle ? $urandom_range(0, MAX_IDLE) : 0;
      if (gap > 0) begin
        rsp_ready = 1'b0;
        repeat (gap) @(negedge clk);
      end
      rsp_ready = 1'b1;
      do @(posedge clk); while (!rsp_valid);
      if (answers_due.size() == 0) begin
        errors++;
        if (errors <= REPORT_MAX) $display("%0t unexpected beat: %s", $time, beat_text(rsp));
      end else begin
        want = answers_due.pop_front();
        if (rsp.kind !== want.kind || rsp.status !== want.status ||
            rsp.slot_out !== want.slot_out || rsp.shown_frame !== want.shown_frame ||
            rsp.rel_frame !== want.rel_frame || rsp.anim_done !== want.anim_done ||
            rsp.last !== want.last) begin
          errors++;
          if (errors <= REPORT_MAX) begin
            $display("%0t beat mismatch\n  expected %s\n  actual   %s", $time,
                     beat_text(want), beat_text(rsp));
          end
        end
      end
    end
  end

  initial begin : req_side
    plan_row_t plan [26];
    int        sl;
    int        lim;
    int        pick;
    bit        held;
    bit        drained;
    plan = '{
      '{OP_QUERY, 3, 0, 0, 0, 0, 0, 0, 1,
        beat_of(KIND_QUERY, STATUS_INVALID, 3, 0, 0, 1, 1)},
      '{OP_FREE, 0, 0, 0, 0, 0, 0, 0, 1,
        beat_of(KIND_ACK, STATUS_INVALID, 0, 0, 0, 0, 1)},
      '{OP_UNKNOWN, 5, 1, 1, 8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF, 1,
        beat_of(KIND_ACK, STATUS_INVALID, 0, 0, 0, 0, 1)},
      '{OP_TICK, 0, 1, 0, 0, 0, 0, 0, 1,
        beat_of(KIND_TICK_DONE, STATUS_OK, 0, 0, 0, 0, 1)},
      '{OP_ALLOC, 9, 0, 0, 0, 0, 0, 0, 1,
        beat_of(KIND_ACK, STATUS_OK, 0, 0, 0, 0, 1)},
      '{OP_ALLOC, 0, 0, 0, 0, 0, 0, 0, 1,
        beat_of(KIND_ACK, STATUS_OK, 1, 0, 0, 0, 1)},
      '{OP_QUERY, 0, 0, 0, 0, 0, 0, 0, 1,
        beat_of(KIND_QUERY, STATUS_OK, 0, 0, 0, 1, 1)},
      '{OP_PLACE, 0, 1, 0, 0, 0, 0, 0, 1,
        beat_of(KIND_ACK, STATUS_OK, 0, 0, 0, 0, 1)},
      '{OP_SET_ANIM, 0, 1, 0, 8'hFF, 0, 3, 16'hFFFF, 1,
        beat_of(KIND_FRAME, STATUS_OK, 0, 16'hFFFF, 0, 0, 1)},
      '{OP_SET_ANIM, 0, 0, 0, 8'hFF, 7, 9, 1, 1,
        beat_of(KIND_ACK, STATUS_OK, 0, 0, 0, 0, 1)},
      '{OP_TICK, 0, 0, 0, 0, 0, 0, 0, 0, NO_BEAT},
      '{OP_TICK, 0, 0, 0, 0, 0, 0, 0, 0, NO_BEAT},
      '{OP_TICK, 0, 0, 0, 0, 0, 0, 0, 0, NO_BEAT},
      '{OP_TICK, 0, 1, 0, 0, 0, 0, 0, 0, NO_BEAT},
      '{OP_SET_FRAME, 0, 0, 0, 0, 0, 5, 5, 1,
        beat_of(KIND_ACK, STATUS_INVALID, 0, 0, 0, 0, 1)},
      '{OP_SET_FRAME, 1, 0, 0, 0, 0, 16'hFFFE, 16'hFFFF, 1,
        beat_of(KIND_FRAME, STATUS_OK, 1, 16'hFFFE, 16'hFFFE, 0, 1)},
      '{OP_SET_FRAME, 1, 0, 0, 0, 0, 16'hFFFE, 16'hFFFF, 1,
        beat_of(KIND_ACK, STATUS_OK, 1, 0, 16'hFFFE, 0, 1)},
      '{OP_SET_ANIM, 1, 0, 0, 0, 0, 0, 0, 1,
        beat_of(KIND_FRAME, STATUS_OK, 1, 0, 0, 0, 1)},
      '{OP_PLACE, 1, 1, 1, 0, 0, 0, 0, 1,
        beat_of(KIND_ACK, STATUS_OK, 1, 0, 0, 0, 1)},
      '{OP_TICK, 0, 1, 0, 0, 0, 0, 0, 0, NO_BEAT},
      '{OP_TICK, 0, 0, 0, 0, 0, 0, 0, 0, NO_BEAT},
      '{OP_QUERY, 1, 0, 0, 0, 0, 0, 0, 0, NO_BEAT},
      '{OP_SET_ANIM, 0, 0, 0, 8'h00, 8'hFF, 16'hFFFF, 16'h1234, 1,
        beat_of(KIND_FRAME, STATUS_OK, 0, 16'h1234, 0, 0, 1)},
      '{OP_FREE, 1, 0, 0, 0, 0, 0, 0, 1,
        beat_of(KIND_ACK, STATUS_OK, 1, 0, 0, 0, 1)},
      '{OP_QUERY, 1, 0, 0, 0, 0, 0, 0, 1,
        beat_of(KIND_QUERY, STATUS_INVALID, 1, 0, 0, 1, 1)},
      '{OP_PLACE, 1, 1, 1, 0, 0, 0, 0, 1,
        beat_of(KIND_ACK, STATUS_INVALID, 1, 0, 0, 0, 1)}
    };
    held = 1'b0;
    drained = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (plan[n]) send_row(plan[n]);

    while (beats_sent < $size(plan) + RAND_ITEMS) begin
      req_idle = ($urandom_range(0, 3) != 0);
      rsp_idle = ($urandom_range(0, 3) != 0);
      if (!held && beats_sent > 70) begin
        // response side stalls while commands keep coming
        held = 1'b1;
        req_idle = 1'b0;
        hold_rsp = 1'b1;
        repeat (12) send_row(cmd_row(OP_TICK, 0, 1'($urandom_range(0, 1)), 0, 0, 0, 0, 0));
      end
      if (!drained && beats_sent > 110) begin
        drained = 1'b1;
        req_valid = 1'b0;
        while (answers_due.size() != 0) @(negedge clk);
      end
      pick = (beats_sent == $size(plan)) ? 0 : $urandom_range(1, 10);
      case (pick)
        0: begin
          while (lowest_free() >= 0) send_row(cmd_row(OP_ALLOC, 0, 0, 0, 0, 0, 0, 0));
          send_row(cmd_row(OP_ALLOC, $urandom_range(0, 15), 0, 0, 0, 0, 0, 0));
        end
        1, 2, 3: begin
          sl = lowest_free();
          if (sl >= 0) send_row(cmd_row(OP_ALLOC, $urandom_range(0, 15), 0, 0, 0, 0, 0, 0));
          else sl = pick_active();
          send_row(cmd_row(OP_PLACE, sl, ($urandom_range(0, 5) != 0),
                           1'($urandom_range(0, 1)), 0, 0, 0, 0));
          send_anim(sl);
        end
        4, 5, 6: begin
          repeat ($urandom_range(1, 5)) begin
            send_row(cmd_row(OP_TICK, 0, ($urandom_range(0, 3) == 0), 0, 0, 0, 0, 0));
          end
        end
        7: begin
          sl = pick_active();
          lim = (s_animated[sl] && s_nframes[sl] != 0) ? s_nframes[sl]
                                                         : $urandom_range(1, 65535);
          send_row(cmd_row(OP_SET_FRAME, sl, 0, 0, 0, 0,
                           ($urandom_range(0, 3) == 0) ? s_frame[sl]
                                                       : $urandom_range(0, lim - 1), lim));
        end
        8: begin
          sl = pick_active();
          send_row(cmd_row(OP_QUERY, sl, 0, 0, 0, 0, 0, 0));
          if ($urandom_range(0, 1)) send_anim(sl);
        end
        9: begin
          repeat ($urandom_range(1, 3)) send_row(cmd_row(OP_FREE, pick_active(), 0, 0,
                                                         0, 0, 0, 0));
        end
        default: begin
          repeat ($urandom_range(1, 3)) begin
            send_row(cmd_row(3'($urandom_range(0, 7)), $urandom_range(0, 15),
                             1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                             $urandom_range(0, 255), $urandom_range(0, 255),
                             $urandom_range(0, 65535), $urandom_range(0, 65535)));
          end
        end
      endcase
    end

    req_valid = 1'b0;
    while (answers_due.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (errors == 0 && answers_due.size() == 0) begin
      $display("sprite_animation_slot_table_tb: clean");
    end else begin
      $display("sprite_animation_slot_table_tb: errors");
    end
    $finish;
  end

endmodule
